### hdl/dspd_pkg.sv
// ----------------------------------------------------------------------------
// dspd_pkg - shared types and constants for the straight-drive PD controller
// Item codes, status codes, register map, reset values and datapath widths.
// ----------------------------------------------------------------------------
package dspd_pkg;

	// encoder count width and ramp length
	localparam int ENC_BITS   = 21;
	localparam int RAMP_TICKS = 50;
	localparam int RAMP_W     = $clog2(RAMP_TICKS + 1);

	// fixed field widths
	localparam int MM_W      = 16;
	localparam int ELAPSED_W = 20;
	localparam int GAIN_W    = 12;
	localparam int CAP_W     = 7;
	localparam int FACTOR_W  = 6;
	localparam int TOL_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 12;

	// millimetres to encoder ticks, Q16
	localparam int MM_TO_TICKS_W = 18;
	localparam logic [MM_TO_TICKS_W-1:0] MM_TO_TICKS_Q16 = 18'd147813;
	localparam int TICK_W  = 17;
	localparam int TGT_W   = TICK_W + 1;
	localparam int TLIM_W  = FACTOR_W + TICK_W;

	// ramp limits need one bit above the cap range (odd cap overshoot)
	localparam int RAMP_LIM_W = CAP_W + 2;
	localparam logic signed [RAMP_LIM_W-1:0] RAMP_STEP = 2;

	// error and product widths
	localparam int SUM_W = ENC_BITS + 1;
	localparam int SE_W  = ((SUM_W > TGT_W) ? SUM_W : TGT_W) + 1;
	localparam int HE_W  = ENC_BITS + 1;
	localparam int DE_W  = SE_W + 1;
	localparam int DH_W  = HE_W + 1;
	localparam int SGAIN_W = GAIN_W + 1;
	localparam int SP_W  = SE_W + SGAIN_W;
	localparam int SD_W  = DE_W + SGAIN_W;
	localparam int SS_W  = SD_W + 1;
	localparam int SO_W  = SS_W - 8;
	localparam int HP_W  = HE_W + SGAIN_W;
	localparam int HD_W  = DH_W + SGAIN_W;
	localparam int HS_W  = HD_W + 1;
	localparam int HO_W  = HS_W - 8;
	localparam int MIX_W = HO_W + 1;

	localparam int POWER_W = 8;
	localparam int POWER_MAX = 127;

	// item codes
	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} opcode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_IDLE      = 2'd0,
		ST_RUNNING   = 2'd1,
		ST_ARRIVED   = 2'd2,
		ST_TIMED_OUT = 2'd3
	} status_t;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRAIGHT_KP = 3'd0,
		REG_STRAIGHT_KD = 3'd1,
		REG_HEADING_KP  = 3'd2,
		REG_HEADING_KD  = 3'd3,
		REG_SPEED_CAP   = 3'd4,
		REG_TIMEOUT_FACTOR = 3'd5,
		REG_DIST_TOL    = 3'd6,
		REG_HEAD_TOL    = 3'd7
	} cfg_reg_t;

	// register reset values
	localparam logic [GAIN_W-1:0]   RST_STRAIGHT_KP = 12'd256;
	localparam logic [GAIN_W-1:0]   RST_STRAIGHT_KD = 12'd512;
	localparam logic [GAIN_W-1:0]   RST_HEADING_KP  = 12'd256;
	localparam logic [GAIN_W-1:0]   RST_HEADING_KD  = 12'd141;
	localparam logic [CAP_W-1:0]    RST_SPEED_CAP   = 7'd35;
	localparam logic [FACTOR_W-1:0] RST_TIMEOUT_FACTOR = 6'd7;
	localparam logic [TOL_W-1:0]    RST_DIST_TOL    = 10'd130;
	localparam logic [TOL_W-1:0]    RST_HEAD_TOL    = 10'd10;

endpackage

### hdl/drive_straight_pd_controller_top.sv
// ----------------------------------------------------------------------------
// drive_straight_pd_controller_top - two-loop PD controller for a straight move
// Start beats set the tick target and timeout; tick beats run the straight and
// heading PD loops with a ramped straight clamp and give the motor commands.
// ----------------------------------------------------------------------------
// Pipeline: the input register loads on the accepting edge of a beat, then the
// state/error, product, sum and output registers follow in that order, and the
// result is valid once the output register has loaded.
// Throughput: one beat per cycle until output stalls fill the empty stages; move
// state changes in the error stage alone, so back-to-back beats need no stall.
// Reset: arst_n clears the pipeline, the move state (no move running) and
// loads the register reset values; the configuration port is always ready.
module drive_straight_pd_controller_top (
	input  logic clk,
	input  logic arst_n,
	// input channel
	input  logic in_valid,
	output logic in_stall,
	input  logic opcode,
	input  logic signed [dspd_pkg::MM_W-1:0]       distance_mm,
	input  logic signed [dspd_pkg::ENC_BITS-1:0]   left_count,
	input  logic signed [dspd_pkg::ENC_BITS-1:0]   right_count,
	input  logic        [dspd_pkg::ELAPSED_W-1:0]  elapsed_ms,
	// output channel
	output logic out_valid,
	input  logic out_stall,
	output logic signed [dspd_pkg::POWER_W-1:0] left_power,
	output logic signed [dspd_pkg::POWER_W-1:0] right_power,
	output logic [1:0] move_status,
	// configuration write channel
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [dspd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dspd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// ------------------------------------------------------------------
	// configuration registers
	logic [dspd_pkg::GAIN_W-1:0]   straight_kp_q, straight_kd_q, heading_kp_q, heading_kd_q;
	logic [dspd_pkg::CAP_W-1:0]    speed_cap_q;
	logic [dspd_pkg::FACTOR_W-1:0] timeout_factor_q;
	logic [dspd_pkg::TOL_W-1:0]    dist_tol_q, head_tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			straight_kp_q    <= dspd_pkg::RST_STRAIGHT_KP;
			straight_kd_q    <= dspd_pkg::RST_STRAIGHT_KD;
			heading_kp_q     <= dspd_pkg::RST_HEADING_KP;
			heading_kd_q     <= dspd_pkg::RST_HEADING_KD;
			speed_cap_q      <= dspd_pkg::RST_SPEED_CAP;
			timeout_factor_q <= dspd_pkg::RST_TIMEOUT_FACTOR;
			dist_tol_q       <= dspd_pkg::RST_DIST_TOL;
			head_tol_q       <= dspd_pkg::RST_HEAD_TOL;
		end else if (cfg_valid && cfg_ready) begin
			case (dspd_pkg::cfg_reg_t'(cfg_index))
				dspd_pkg::REG_STRAIGHT_KP:    straight_kp_q <= cfg_data;
				dspd_pkg::REG_STRAIGHT_KD:    straight_kd_q <= cfg_data;
				dspd_pkg::REG_HEADING_KP:     heading_kp_q  <= cfg_data;
				dspd_pkg::REG_HEADING_KD:     heading_kd_q  <= cfg_data;
				dspd_pkg::REG_SPEED_CAP:      speed_cap_q   <= cfg_data[dspd_pkg::CAP_W-1:0];
				dspd_pkg::REG_TIMEOUT_FACTOR:
					timeout_factor_q <= cfg_data[dspd_pkg::FACTOR_W-1:0];
				dspd_pkg::REG_DIST_TOL:       dist_tol_q    <= cfg_data[dspd_pkg::TOL_W-1:0];
				dspd_pkg::REG_HEAD_TOL:       head_tol_q    <= cfg_data[dspd_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// stage handshake: a stage loads when it is empty or moving on
	logic v1_s1, v2_s2, v3_s3, v4_s4, out_valid_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;

	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy4     = !v4_s4 || rdy_out;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1       <= 1'b0;
			v2_s2       <= 1'b0;
			v3_s3       <= 1'b0;
			v4_s4       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)    v1_s1       <= in_valid;
			if (rdy2)    v2_s2       <= v1_s1;
			if (rdy3)    v3_s3       <= v2_s2;
			if (rdy4)    v4_s4       <= v3_s3;
			if (rdy_out) out_valid_q <= v4_s4;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: input register, distance converted to ticks on the way in
	logic [dspd_pkg::MM_W-1:0] mm_mag;
	logic [dspd_pkg::MM_W+dspd_pkg::MM_TO_TICKS_W-1:0] mm_prod;

	assign mm_mag  = distance_mm[dspd_pkg::MM_W-1] ? (~distance_mm + 1'b1) : distance_mm;
	assign mm_prod = mm_mag * dspd_pkg::MM_TO_TICKS_Q16;

	logic op_s1, neg_s1;
	logic [dspd_pkg::TICK_W-1:0] ticks_s1;
	logic signed [dspd_pkg::ENC_BITS-1:0] left_s1, right_s1;
	logic [dspd_pkg::ELAPSED_W-1:0] elapsed_s1;

	always_ff @(posedge clk) begin
		if (in_valid && rdy1) begin
			op_s1      <= opcode;
			neg_s1     <= distance_mm[dspd_pkg::MM_W-1];
			ticks_s1   <= mm_prod[16 +: dspd_pkg::TICK_W];
			left_s1    <= left_count;
			right_s1   <= right_count;
			elapsed_s1 <= elapsed_ms;
		end
	end

	// ------------------------------------------------------------------
	// move state
	logic signed [dspd_pkg::TGT_W-1:0]      target_q;
	logic [dspd_pkg::ELAPSED_W-1:0]         time_limit_q;
	logic signed [dspd_pkg::SE_W-1:0]       se_prev_q;
	logic signed [dspd_pkg::HE_W-1:0]       he_prev_q;
	logic signed [dspd_pkg::RAMP_LIM_W-1:0] ramp_low_q, ramp_high_q;
	logic [dspd_pkg::RAMP_W-1:0]            ramp_ticks_q;
	logic signed [dspd_pkg::ENC_BITS-1:0]   prev_left_q;
	logic                                   active_q;

	// stage 2 logic: errors, ramp step, timeout and arrival checks
	logic signed [dspd_pkg::TGT_W-1:0]      tgt_new;
	logic [dspd_pkg::TLIM_W-1:0]            tlim_prod;
	logic [dspd_pkg::ELAPSED_W-1:0]         tlim_new;
	logic signed [dspd_pkg::SUM_W-1:0]      sum_lr;
	logic signed [dspd_pkg::SE_W-1:0]       se;
	logic signed [dspd_pkg::HE_W-1:0]       he;
	logic [dspd_pkg::SE_W-1:0]              se_mag;
	logic [dspd_pkg::HE_W-1:0]              he_mag;
	logic signed [dspd_pkg::RAMP_LIM_W-1:0] cap_s;
	logic signed [dspd_pkg::RAMP_LIM_W-1:0] ramp_low_n, ramp_high_n;
	logic [dspd_pkg::RAMP_W-1:0]            ramp_ticks_n;
	logic timed_out, rising, settled, a_go;

	assign a_go = v1_s1 && rdy2;

	always_comb begin
		tgt_new   = neg_s1 ? -$signed({1'b0, ticks_s1}) : $signed({1'b0, ticks_s1});
		tlim_prod = timeout_factor_q * ticks_s1;
		tlim_new  = (|tlim_prod[dspd_pkg::TLIM_W-1:dspd_pkg::ELAPSED_W]) ?
			{dspd_pkg::ELAPSED_W{1'b1}} : tlim_prod[dspd_pkg::ELAPSED_W-1:0];

		sum_lr = dspd_pkg::SUM_W'(left_s1) + dspd_pkg::SUM_W'(right_s1);
		se     = dspd_pkg::SE_W'(target_q) - dspd_pkg::SE_W'(sum_lr);
		he     = dspd_pkg::HE_W'(left_s1) - dspd_pkg::HE_W'(right_s1);
		se_mag = se[dspd_pkg::SE_W-1] ? dspd_pkg::SE_W'(-se) : dspd_pkg::SE_W'(se);
		he_mag = he[dspd_pkg::HE_W-1] ? dspd_pkg::HE_W'(-he) : dspd_pkg::HE_W'(he);

		// limits step by two until the ramp count is spent, then sit on the cap
		cap_s = $signed({2'b00, speed_cap_q});
		if (ramp_ticks_q < dspd_pkg::RAMP_W'(dspd_pkg::RAMP_TICKS)) begin
			ramp_low_n   = (ramp_low_q > -cap_s) ? ramp_low_q - dspd_pkg::RAMP_STEP : ramp_low_q;
			ramp_high_n  = (ramp_high_q < cap_s) ? ramp_high_q + dspd_pkg::RAMP_STEP
				: ramp_high_q;
			ramp_ticks_n = ramp_ticks_q + 1'b1;
		end else begin
			ramp_low_n   = -cap_s;
			ramp_high_n  = cap_s;
			ramp_ticks_n = ramp_ticks_q;
		end

		timed_out = elapsed_s1 > time_limit_q;
		rising    = left_s1 > prev_left_q;
		settled   = (se_mag <= dspd_pkg::SE_W'(dist_tol_q))
			&& (he_mag <= dspd_pkg::HE_W'(head_tol_q)) && !rising;
	end

	// state update, one beat at a time as it leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q     <= '0;
			time_limit_q <= '0;
			se_prev_q    <= '0;
			he_prev_q    <= '0;
			ramp_low_q   <= '0;
			ramp_high_q  <= '0;
			ramp_ticks_q <= '0;
			prev_left_q  <= '0;
			active_q     <= 1'b0;
		end else if (a_go) begin
			if (dspd_pkg::opcode_t'(op_s1) == dspd_pkg::OP_START) begin
				target_q     <= tgt_new;
				time_limit_q <= tlim_new;
				se_prev_q    <= '0;
				he_prev_q    <= '0;
				ramp_low_q   <= '0;
				ramp_high_q  <= '0;
				ramp_ticks_q <= '0;
				prev_left_q  <= '0;
				active_q     <= 1'b1;
			end else if (active_q) begin
				se_prev_q    <= se;
				he_prev_q    <= he;
				ramp_low_q   <= ramp_low_n;
				ramp_high_q  <= ramp_high_n;
				ramp_ticks_q <= ramp_ticks_n;
				if (timed_out) begin
					active_q <= 1'b0;
				end else begin
					prev_left_q <= left_s1;
					if (settled) active_q <= 1'b0;
				end
			end
		end
	end

	// stage 2 register
	dspd_pkg::status_t status_s2;
	logic signed [dspd_pkg::SE_W-1:0]       se_s2;
	logic signed [dspd_pkg::DE_W-1:0]       de_s2;
	logic signed [dspd_pkg::HE_W-1:0]       he_s2;
	logic signed [dspd_pkg::DH_W-1:0]       dh_s2;
	logic signed [dspd_pkg::RAMP_LIM_W-1:0] lo_s2, hi_s2;

	always_ff @(posedge clk) begin
		if (a_go) begin
			se_s2 <= se;
			de_s2 <= dspd_pkg::DE_W'(se) - dspd_pkg::DE_W'(se_prev_q);
			he_s2 <= he;
			dh_s2 <= dspd_pkg::DH_W'(he) - dspd_pkg::DH_W'(he_prev_q);
			lo_s2 <= ramp_low_n;
			hi_s2 <= ramp_high_n;
			if (dspd_pkg::opcode_t'(op_s1) == dspd_pkg::OP_START || !active_q)
				status_s2 <= dspd_pkg::ST_IDLE;
			else if (timed_out)
				status_s2 <= dspd_pkg::ST_TIMED_OUT;
			else if (settled)
				status_s2 <= dspd_pkg::ST_ARRIVED;
			else
				status_s2 <= dspd_pkg::ST_RUNNING;
		end
	end

	// ------------------------------------------------------------------
	// stage 3: gain products
	dspd_pkg::status_t status_s3;
	logic signed [dspd_pkg::SP_W-1:0] sp_s3;
	logic signed [dspd_pkg::SD_W-1:0] sd_s3;
	logic signed [dspd_pkg::HP_W-1:0] hp_s3;
	logic signed [dspd_pkg::HD_W-1:0] hd_s3;
	logic signed [dspd_pkg::RAMP_LIM_W-1:0] lo_s3, hi_s3;

	always_ff @(posedge clk) begin
		if (v2_s2 && rdy3) begin
			sp_s3     <= $signed({1'b0, straight_kp_q}) * se_s2;
			sd_s3     <= $signed({1'b0, straight_kd_q}) * de_s2;
			hp_s3     <= $signed({1'b0, heading_kp_q}) * he_s2;
			hd_s3     <= $signed({1'b0, heading_kd_q}) * dh_s2;
			lo_s3     <= lo_s2;
			hi_s3     <= hi_s2;
			status_s3 <= status_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 4: sums scaled by 1/256 toward zero, straight term clamped
	logic signed [dspd_pkg::SS_W-1:0] ssum, ssum_adj;
	logic signed [dspd_pkg::HS_W-1:0] hsum, hsum_adj;
	logic signed [dspd_pkg::SO_W-1:0] so_full;
	logic signed [dspd_pkg::HO_W-1:0] ho_full;
	logic signed [dspd_pkg::RAMP_LIM_W-1:0] so_clamped;

	always_comb begin
		ssum     = dspd_pkg::SS_W'(sp_s3) + dspd_pkg::SS_W'(sd_s3);
		hsum     = dspd_pkg::HS_W'(hp_s3) + dspd_pkg::HS_W'(hd_s3);
		ssum_adj = ssum + (ssum[dspd_pkg::SS_W-1] ? dspd_pkg::SS_W'(255) : '0);
		hsum_adj = hsum + (hsum[dspd_pkg::HS_W-1] ? dspd_pkg::HS_W'(255) : '0);
		so_full  = ssum_adj[dspd_pkg::SS_W-1:8];
		ho_full  = hsum_adj[dspd_pkg::HS_W-1:8];
		if (so_full > dspd_pkg::SO_W'(hi_s3))
			so_clamped = hi_s3;
		else if (so_full < dspd_pkg::SO_W'(lo_s3))
			so_clamped = lo_s3;
		else
			so_clamped = so_full[dspd_pkg::RAMP_LIM_W-1:0];
	end

	dspd_pkg::status_t status_s4;
	logic signed [dspd_pkg::RAMP_LIM_W-1:0] so_s4;
	logic signed [dspd_pkg::HO_W-1:0]       ho_s4;

	always_ff @(posedge clk) begin
		if (v3_s3 && rdy4) begin
			so_s4     <= so_clamped;
			ho_s4     <= ho_full;
			status_s4 <= status_s3;
		end
	end

	// ------------------------------------------------------------------
	// output stage: mix, saturate to the motor range, zero unless running
	function automatic logic signed [dspd_pkg::POWER_W-1:0] sat_power(
		input logic signed [dspd_pkg::MIX_W-1:0] x
	);
		logic signed [dspd_pkg::MIX_W-1:0] pmax;
		pmax = dspd_pkg::MIX_W'(dspd_pkg::POWER_MAX);
		if (x > pmax)
			return dspd_pkg::POWER_W'(dspd_pkg::POWER_MAX);
		else if (x < -pmax)
			return -dspd_pkg::POWER_W'(dspd_pkg::POWER_MAX);
		else
			return x[dspd_pkg::POWER_W-1:0];
	endfunction

	logic signed [dspd_pkg::MIX_W-1:0] mix_l, mix_r;
	logic signed [dspd_pkg::POWER_W-1:0] left_power_q, right_power_q;
	dspd_pkg::status_t status_q;

	assign mix_l = dspd_pkg::MIX_W'(so_s4) - dspd_pkg::MIX_W'(ho_s4);
	assign mix_r = dspd_pkg::MIX_W'(so_s4) + dspd_pkg::MIX_W'(ho_s4);

	always_ff @(posedge clk) begin
		if (v4_s4 && rdy_out) begin
			status_q <= status_s4;
			if (status_s4 == dspd_pkg::ST_RUNNING) begin
				left_power_q  <= sat_power(mix_l);
				right_power_q <= sat_power(mix_r);
			end else begin
				left_power_q  <= '0;
				right_power_q <= '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign left_power  = left_power_q;
	assign right_power = right_power_q;
	assign move_status = status_q;

`ifndef SYNTHESIS
	// a result that is not a running beat drives nothing
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && move_status != dspd_pkg::ST_RUNNING |-> left_power == '0 && right_power == '0)
		else $error("motor drive on a non-running result");

	// saturation keeps the commands symmetric
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_power != -8'sd128 && right_power != -8'sd128)
		else $error("motor command outside the saturated range");

	// a start beat leaving stage 1 always begins a move
	assert property (@(posedge clk) disable iff (!arst_n)
		a_go && op_s1 == dspd_pkg::OP_START |=> active_q && ramp_ticks_q == '0)
		else $error("start beat did not begin a move");

	// ramp limits never cross zero
	assert property (@(posedge clk) disable iff (!arst_n)
		ramp_low_q <= 0 && ramp_high_q >= 0)
		else $error("ramp limits crossed zero");

	// an empty input stage never holds off the sender
	assert property (@(posedge clk) disable iff (!arst_n)
		!v1_s1 |-> !in_stall)
		else $error("stall raised with an empty input stage");
`endif

endmodule
